@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of the detection row decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while dis is high
`define DRDF_ASSERT_SAME(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("drdf assertion failed");

// Next-cycle implication, disabled while dis is high
`define DRDF_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("drdf assertion failed");

`endif

@@ design/drdf_pkg.sv @@
// Package: widths, register map and row layout of the detection row decoder.
`default_nettype none

package drdf_pkg;

    // field widths
    localparam int VALUE_W  = 32;
    localparam int CLASS_W  = 7;
    localparam int OBJ_W    = 17;
    localparam int THR_W    = 17;
    localparam int FACTOR_W = 24;
    localparam int BOX_W    = 16;

    // configuration port
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_CONF_THRESH  = 3'd0,
        REG_SCORE_THRESH = 3'd1,
        REG_X_FACTOR     = 3'd2,
        REG_Y_FACTOR     = 3'd3,
        REG_CLASS_COUNT  = 3'd4
    } t_reg_idx;

    // register reset values
    localparam logic [THR_W-1:0]    CONF_THRESH_RST  = 17'd29491;
    localparam logic [THR_W-1:0]    SCORE_THRESH_RST = 17'd32768;
    localparam logic [FACTOR_W-1:0] FACTOR_RST       = 24'd65536;
    localparam logic [CLASS_W-1:0]  CLASS_COUNT_RST  = 7'd80;

    // row layout
    localparam int POS_CX          = 0;
    localparam int POS_CY          = 1;
    localparam int POS_W           = 2;
    localparam int POS_H           = 3;
    localparam int POS_OBJ         = 4;
    localparam int FIRST_CLASS_POS = 5;

    // objectness ceiling, 1.0 in Q16
    localparam logic [OBJ_W-1:0] OBJ_MAX = 17'd65536;

endpackage

`default_nettype wire

@@ design/detection_row_decode_filter.sv @@
// Top level: streaming decoder of detector output rows into filtered detections.
//
// Input channel: one signed Q15.16 row element per word (i_valid / o_stall).
// A row is ROW_LENGTH words: center x, center y, width, height, objectness,
// then class scores. The block tracks the first-maximum class argmax over
// the first class_count scores and, on the last word of a row, decides
// whether the row is a detection.
// Output channel: one word per passing row (o_valid / i_stall) with class
// index, saturated objectness and the scaled box in pixels.
// Throughput: one input word per cycle while o_stall is low. A detection is
// registered in turn as the snapshot, the four 32x24 products, the edge
// numerators, and the truncated, saturated output register.
// Stall: a receiver stall backs up the four result stages; the input is
// stalled only when the snapshot stage is full and cannot drain.
// Reset (i_rst_n low at a clock edge): registers return to defaults, the row
// position and trackers clear, and all result stages empty.
// Configuration: APB registers at 4*i; the user must write them only while
// the stream is idle, and the block itself does not enforce this.
`default_nettype none

module detection_row_decode_filter #(
    parameter int ROW_LENGTH  = 85,
    parameter int MAX_CLASSES = 80
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // element stream
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [drdf_pkg::VALUE_W-1:0] i_element_value,
    // detection stream
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [drdf_pkg::CLASS_W-1:0]        o_class_index,
    output logic [drdf_pkg::OBJ_W-1:0]          o_objectness,
    output logic signed [drdf_pkg::BOX_W-1:0]   o_box_left,
    output logic signed [drdf_pkg::BOX_W-1:0]   o_box_top,
    output logic [drdf_pkg::BOX_W-1:0]          o_box_width,
    output logic [drdf_pkg::BOX_W-1:0]          o_box_height,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [drdf_pkg::ADDR_W-1:0]         paddr,
    input  logic [drdf_pkg::DATA_W-1:0]         pwdata,
    output logic [drdf_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    localparam int POS_BITS = $clog2(ROW_LENGTH);
    localparam int PROD_W   = drdf_pkg::VALUE_W + drdf_pkg::FACTOR_W;
    localparam int NUM_W    = PROD_W + 2;
    localparam logic [POS_BITS-1:0] LAST_POS = POS_BITS'(ROW_LENGTH - 1);
    localparam logic [drdf_pkg::CLASS_W-1:0] MAX_CLS = drdf_pkg::CLASS_W'(MAX_CLASSES);

    // Truncate an edge numerator (Q33 pixels) toward zero and saturate to 16 bits
    function automatic logic signed [drdf_pkg::BOX_W-1:0] edge_px(
        input logic signed [NUM_W-1:0] num
    );
        logic signed [NUM_W-34:0] q;
        logic                     corr;
        logic signed [NUM_W-33:0] t;
        q    = num[NUM_W-1:33];
        corr = num[NUM_W-1] & (|num[32:0]);
        t    = $signed({q[NUM_W-34], q}) + $signed({{(NUM_W-33){1'b0}}, corr});
        if (t > $signed((NUM_W-32)'(32767))) begin
            return 16'sh7fff;
        end else if (t < -$signed((NUM_W-32)'(32768))) begin
            return 16'sh8000;
        end else begin
            return t[drdf_pkg::BOX_W-1:0];
        end
    endfunction

    // Truncate a size product (Q32 pixels) toward zero and saturate to 0..65535
    function automatic logic [drdf_pkg::BOX_W-1:0] size_px(
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [PROD_W-33:0] q;
        logic                      corr;
        logic signed [PROD_W-32:0] t;
        q    = prod[PROD_W-1:32];
        corr = prod[PROD_W-1] & (|prod[31:0]);
        t    = $signed({q[PROD_W-33], q}) + $signed({{(PROD_W-32){1'b0}}, corr});
        if (t[PROD_W-32]) begin
            return '0;
        end else if (t > $signed((PROD_W-31)'(65535))) begin
            return 16'hffff;
        end else begin
            return t[drdf_pkg::BOX_W-1:0];
        end
    endfunction

    // configuration registers
    logic [drdf_pkg::THR_W-1:0]    r_conf_thresh;
    logic [drdf_pkg::THR_W-1:0]    r_score_thresh;
    logic [drdf_pkg::FACTOR_W-1:0] r_x_factor;
    logic [drdf_pkg::FACTOR_W-1:0] r_y_factor;
    logic [drdf_pkg::CLASS_W-1:0]  r_class_count;
    logic                          w_cfg_wr;
    drdf_pkg::t_reg_idx            w_reg_idx;

    // row trackers
    logic [POS_BITS-1:0]                r_pos;
    logic signed [drdf_pkg::VALUE_W-1:0] r_cx, r_cy, r_w, r_h, r_obj, r_best_score;
    logic [drdf_pkg::CLASS_W-1:0]        r_best_class;
    logic signed [drdf_pkg::VALUE_W-1:0] n_best_score;
    logic [drdf_pkg::CLASS_W-1:0]        n_best_class;

    logic                          w_accept, w_last, w_is_class, w_take;
    logic                          w_obj_ok, w_score_ok, w_emit;
    logic [drdf_pkg::CLASS_W-1:0]  w_classes, w_cls_k;
    logic [drdf_pkg::OBJ_W-1:0]    w_obj_sat;

    // result stages
    logic                                r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    logic                                w_mv1, w_mv2, w_mv3, w_mv_out;
    logic signed [drdf_pkg::VALUE_W-1:0] r_s1_cx, r_s1_cy, r_s1_w, r_s1_h;
    logic [drdf_pkg::OBJ_W-1:0]          r_s1_obj, r_s2_obj, r_s3_obj;
    logic [drdf_pkg::CLASS_W-1:0]        r_s1_class, r_s2_class, r_s3_class;
    logic signed [PROD_W-1:0]            w_pcx, w_pcy, w_pw, w_ph;
    logic signed [PROD_W-1:0]            r_s2_pcx, r_s2_pcy, r_s2_pw, r_s2_ph;
    logic signed [PROD_W-1:0]            r_s3_pw, r_s3_ph;
    logic signed [NUM_W-1:0]             w_left_num, w_top_num, r_s3_left, r_s3_top;
    logic [drdf_pkg::CLASS_W-1:0]        r_out_class;
    logic [drdf_pkg::OBJ_W-1:0]          r_out_obj;
    logic signed [drdf_pkg::BOX_W-1:0]   r_out_left, r_out_top;
    logic [drdf_pkg::BOX_W-1:0]          r_out_width, r_out_height;

    // Configuration write and readback
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite;
    assign w_reg_idx = drdf_pkg::t_reg_idx'(paddr[drdf_pkg::ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conf_thresh  <= drdf_pkg::CONF_THRESH_RST;
            r_score_thresh <= drdf_pkg::SCORE_THRESH_RST;
            r_x_factor     <= drdf_pkg::FACTOR_RST;
            r_y_factor     <= drdf_pkg::FACTOR_RST;
            r_class_count  <= drdf_pkg::CLASS_COUNT_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                drdf_pkg::REG_CONF_THRESH:  r_conf_thresh  <= pwdata[drdf_pkg::THR_W-1:0];
                drdf_pkg::REG_SCORE_THRESH: r_score_thresh <= pwdata[drdf_pkg::THR_W-1:0];
                drdf_pkg::REG_X_FACTOR:     r_x_factor     <= pwdata[drdf_pkg::FACTOR_W-1:0];
                drdf_pkg::REG_Y_FACTOR:     r_y_factor     <= pwdata[drdf_pkg::FACTOR_W-1:0];
                drdf_pkg::REG_CLASS_COUNT:  r_class_count  <= pwdata[drdf_pkg::CLASS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            drdf_pkg::REG_CONF_THRESH:  prdata = drdf_pkg::DATA_W'(r_conf_thresh);
            drdf_pkg::REG_SCORE_THRESH: prdata = drdf_pkg::DATA_W'(r_score_thresh);
            drdf_pkg::REG_X_FACTOR:     prdata = drdf_pkg::DATA_W'(r_x_factor);
            drdf_pkg::REG_Y_FACTOR:     prdata = drdf_pkg::DATA_W'(r_y_factor);
            drdf_pkg::REG_CLASS_COUNT:  prdata = drdf_pkg::DATA_W'(r_class_count);
            default:                    prdata = '0;
        endcase
    end

    // Stage advance: each stage moves when it is empty or the next one moves
    assign w_mv_out = ~r_out_valid | ~i_stall;
    assign w_mv3    = ~r_s3_valid | w_mv_out;
    assign w_mv2    = ~r_s2_valid | w_mv3;
    assign w_mv1    = ~r_s1_valid | w_mv2;
    assign o_stall  = ~w_mv1;
    assign w_accept = i_valid & ~o_stall;

    // Argmax over the active class scores, first maximum wins
    assign w_classes  = (r_class_count > MAX_CLS) ? MAX_CLS : r_class_count;
    assign w_is_class = r_pos >= POS_BITS'(drdf_pkg::FIRST_CLASS_POS);
    assign w_cls_k    = drdf_pkg::CLASS_W'(r_pos - POS_BITS'(drdf_pkg::FIRST_CLASS_POS));
    assign w_take     = w_is_class && (w_cls_k < w_classes)
                        && ((w_cls_k == '0) || (i_element_value > r_best_score));
    assign n_best_score = w_take ? i_element_value : r_best_score;
    assign n_best_class = w_take ? w_cls_k : r_best_class;

    // Row-end decision
    assign w_last     = r_pos == LAST_POS;
    assign w_obj_ok   = $signed({r_obj[drdf_pkg::VALUE_W-1], r_obj})
                        >= $signed({16'b0, r_conf_thresh});
    assign w_score_ok = $signed({n_best_score[drdf_pkg::VALUE_W-1], n_best_score})
                        > $signed({16'b0, r_score_thresh});
    assign w_emit     = w_accept && w_last && (w_classes != '0) && w_obj_ok && w_score_ok;

    // Saturate objectness to 0..1.0
    always_comb begin
        if (r_obj[drdf_pkg::VALUE_W-1]) begin
            w_obj_sat = '0;
        end else if (r_obj > $signed(drdf_pkg::VALUE_W'(drdf_pkg::OBJ_MAX))) begin
            w_obj_sat = drdf_pkg::OBJ_MAX;
        end else begin
            w_obj_sat = r_obj[drdf_pkg::OBJ_W-1:0];
        end
    end

    // Capture row fields and advance the element position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_cx         <= '0;
            r_cy         <= '0;
            r_w          <= '0;
            r_h          <= '0;
            r_obj        <= '0;
            r_best_score <= '0;
            r_best_class <= '0;
        end else if (w_accept) begin
            r_pos        <= w_last ? '0 : r_pos + 1'b1;
            r_best_score <= n_best_score;
            r_best_class <= n_best_class;
            if (r_pos == POS_BITS'(drdf_pkg::POS_CX)) begin
                r_cx <= i_element_value;
            end
            if (r_pos == POS_BITS'(drdf_pkg::POS_CY)) begin
                r_cy <= i_element_value;
            end
            if (r_pos == POS_BITS'(drdf_pkg::POS_W)) begin
                r_w <= i_element_value;
            end
            if (r_pos == POS_BITS'(drdf_pkg::POS_H)) begin
                r_h <= i_element_value;
            end
            if (r_pos == POS_BITS'(drdf_pkg::POS_OBJ)) begin
                r_obj <= i_element_value;
            end
        end
    end

    // Products of the box fields with the scale factors
    assign w_pcx = r_s1_cx * $signed({1'b0, r_x_factor});
    assign w_pw  = r_s1_w  * $signed({1'b0, r_x_factor});
    assign w_pcy = r_s1_cy * $signed({1'b0, r_y_factor});
    assign w_ph  = r_s1_h  * $signed({1'b0, r_y_factor});

    // Edge numerators: 2*c*f - w*f in Q33
    assign w_left_num = $signed({r_s2_pcx[PROD_W-1], r_s2_pcx, 1'b0})
                        - $signed({{2{r_s2_pw[PROD_W-1]}}, r_s2_pw});
    assign w_top_num  = $signed({r_s2_pcy[PROD_W-1], r_s2_pcy, 1'b0})
                        - $signed({{2{r_s2_ph[PROD_W-1]}}, r_s2_ph});

    // Result stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_mv1) begin
                r_s1_valid <= w_emit;
            end
            if (w_mv2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_mv3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (w_mv_out) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    // Result stage payloads
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_s1_cx    <= r_cx;
            r_s1_cy    <= r_cy;
            r_s1_w     <= r_w;
            r_s1_h     <= r_h;
            r_s1_obj   <= w_obj_sat;
            r_s1_class <= n_best_class;
        end
        if (w_mv2 && r_s1_valid) begin
            r_s2_pcx   <= w_pcx;
            r_s2_pcy   <= w_pcy;
            r_s2_pw    <= w_pw;
            r_s2_ph    <= w_ph;
            r_s2_obj   <= r_s1_obj;
            r_s2_class <= r_s1_class;
        end
        if (w_mv3 && r_s2_valid) begin
            r_s3_left  <= w_left_num;
            r_s3_top   <= w_top_num;
            r_s3_pw    <= r_s2_pw;
            r_s3_ph    <= r_s2_ph;
            r_s3_obj   <= r_s2_obj;
            r_s3_class <= r_s2_class;
        end
        if (w_mv_out && r_s3_valid) begin
            r_out_left   <= edge_px(r_s3_left);
            r_out_top    <= edge_px(r_s3_top);
            r_out_width  <= size_px(r_s3_pw);
            r_out_height <= size_px(r_s3_ph);
            r_out_obj    <= r_s3_obj;
            r_out_class  <= r_s3_class;
        end
    end

    // Drive the detection word
    assign o_valid       = r_out_valid;
    assign o_class_index = r_out_class;
    assign o_objectness  = r_out_obj;
    assign o_box_left    = r_out_left;
    assign o_box_top     = r_out_top;
    assign o_box_width   = r_out_width;
    assign o_box_height  = r_out_height;

endmodule

`default_nettype wire

@@ design/drdf_checker.sv @@
// Checker for the detection row decoder's output port, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module drdf_checker #(
    parameter int MAX_CLASSES = 80
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic [drdf_pkg::CLASS_W-1:0]      o_class_index,
    input logic [drdf_pkg::OBJ_W-1:0]        o_objectness,
    input logic signed [drdf_pkg::BOX_W-1:0] o_box_left,
    input logic signed [drdf_pkg::BOX_W-1:0] o_box_top,
    input logic [drdf_pkg::BOX_W-1:0]        o_box_width,
    input logic [drdf_pkg::BOX_W-1:0]        o_box_height
);

    localparam logic [drdf_pkg::CLASS_W-1:0] MAX_CLS = drdf_pkg::CLASS_W'(MAX_CLASSES);

    // A stalled detection word holds
    `DRDF_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_valid && i_stall, o_valid && $stable(o_class_index) && $stable(o_objectness) && $stable(o_box_left) && $stable(o_box_top) && $stable(o_box_width) && $stable(o_box_height))

    // Reset empties the result stages
    `DRDF_ASSERT_NEXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, !o_valid)

    // Class index stays below the MAX_CLASSES parameter
    `DRDF_ASSERT_SAME(a_class_range, i_clk, !i_rst_n, o_valid, o_class_index < MAX_CLS)

    // Objectness is saturated to 1.0
    `DRDF_ASSERT_SAME(a_obj_range, i_clk, !i_rst_n, o_valid, o_objectness <= drdf_pkg::OBJ_MAX)

endmodule

bind detection_row_decode_filter drdf_checker #(
    .MAX_CLASSES(MAX_CLASSES)
) u_drdf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_class_index (o_class_index),
    .o_objectness  (o_objectness),
    .o_box_left    (o_box_left),
    .o_box_top     (o_box_top),
    .o_box_width   (o_box_width),
    .o_box_height  (o_box_height)
);

`default_nettype wire
